[rtl/core/tcw_pkg.sv]
package tcw_pkg;

  localparam logic       OP_PUT       = 1'b0;
  localparam logic       OP_READ      = 1'b1;
  localparam logic [7:0] TEXT_ATTR    = 8'h07;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  char_code;
    logic [10:0] cell_address;
  } in_t;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attribute;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_DONE
  } state_e;

endpackage

[rtl/core/tcw_cell_ram.sv]
module tcw_cell_ram #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem_q [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/text_console_writer_top.sv]
// Text console writer.
// Requests arrive on the in channel (in_valid_i / in_ready_o, payload in_data_i).
// A put request writes a character with the default attribute at the cursor
// or handles a newline; a read request fetches one screen cell. Each request
// yields exactly one result on the out channel (out_valid_o / out_ready_i),
// carrying the linear cursor position and, for in-range reads, the cell contents.
// The screen lives in one single-port-write, single-port-read RAM with a
// registered read. A put passes through ST_DONE before its result is
// registered; an in-range read first passes through ST_READ, which captures
// the RAM data, and then ST_DONE. When the cursor runs past the last row the
// screen scrolls (one RAM read and one RAM write per cycle) before the result.
// After reset the block clears every RAM cell in ST_CLEAR and
// holds in_ready_o low meanwhile; the cursor starts at position zero.
// The result register parts the two sides: if the receiver stalls, the
// next request is still accepted and processed, and its result waits until
// the output register frees up. One request is in work at a time.
module text_console_writer_top #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tcw_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tcw_pkg::out_t out_data_o
);

  import tcw_pkg::*;

  localparam int unsigned CELL_COUNT = ROWS * COLUMNS;
  localparam int unsigned AW         = $clog2(CELL_COUNT);
  localparam int unsigned CW         = $clog2(COLUMNS);
  localparam int unsigned RW         = $clog2(ROWS);

  localparam logic [AW-1:0] CELL_LAST = AW'(CELL_COUNT - 1);
  localparam logic [AW-1:0] COPY_END  = AW'(CELL_COUNT - COLUMNS);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);

  state_e        state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] base_q, base_d;
  logic [7:0]    rchar_q, rchar_d;
  logic [7:0]    rattr_q, rattr_d;
  logic          wv_q, wv_d;
  logic [AW-1:0] wa_q, wa_d;
  logic          wcopy_q, wcopy_d;
  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata;

  logic           in_fire;
  logic           out_free;
  logic           is_newline;
  logic           adv_row;
  logic           row_last;
  logic           addr_ok;
  logic           copy_phase;
  logic [AW+10:0] addr_ext;
  logic [AW+10:0] pos_ext;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign is_newline = (in_data_i.char_code == NEWLINE_CODE);
  assign adv_row    = is_newline || (col_q == COL_LAST);
  assign row_last   = (row_q == ROW_LAST);
  assign addr_ok    = (32'(in_data_i.cell_address) < 32'(CELL_COUNT));
  assign copy_phase = (cnt_q < COPY_END);
  assign addr_ext   = {{AW{1'b0}}, in_data_i.cell_address};
  assign pos_ext    = {11'b0, pos_q};

  tcw_cell_ram #(
    .DEPTH (CELL_COUNT),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (cnt_q == CELL_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data_i.opcode == OP_READ) begin
            state_d = addr_ok ? ST_READ : ST_DONE;
          end else if (adv_row && row_last) begin
            state_d = ST_SCROLL;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_READ: state_d = ST_DONE;
      ST_SCROLL: begin
        if (cnt_q == CELL_LAST) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    cnt_d       = cnt_q;
    col_d       = col_q;
    row_d       = row_q;
    pos_d       = pos_q;
    base_d      = base_q;
    rchar_d     = rchar_q;
    rattr_d     = rattr_q;
    wv_d        = 1'b0;
    wa_d        = wa_q;
    wcopy_d     = wcopy_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = wa_q;
    mem_wdata   = 16'h0000;
    mem_re      = 1'b0;
    mem_raddr   = cnt_q + ROW_STEP;

    // Delayed write of the scroll pipeline; the read was issued in the previous cycle.
    if (wv_q) begin
      mem_we    = 1'b1;
      mem_waddr = wa_q;
      mem_wdata = wcopy_q ? mem_rdata : 16'h0000;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = 16'h0000;
        cnt_d     = (cnt_q == CELL_LAST) ? '0 : cnt_q + AW'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          rchar_d = 8'h00;
          rattr_d = 8'h00;
          if (in_data_i.opcode == OP_READ) begin
            mem_re    = addr_ok;
            mem_raddr = addr_ext[AW-1:0];
          end else begin
            if (!is_newline) begin
              mem_we    = 1'b1;
              mem_waddr = pos_q;
              mem_wdata = {TEXT_ATTR, in_data_i.char_code};
            end
            if (adv_row) begin
              col_d = '0;
              if (row_last) begin
                pos_d = base_q;
              end else begin
                row_d  = row_q + RW'(1);
                base_d = base_q + ROW_STEP;
                pos_d  = base_q + ROW_STEP;
              end
            end else begin
              col_d = col_q + CW'(1);
              pos_d = pos_q + AW'(1);
            end
          end
        end
      end
      ST_READ: begin
        rchar_d = mem_rdata[7:0];
        rattr_d = mem_rdata[15:8];
      end
      ST_SCROLL: begin
        // Read the cell one row below, write it back here next cycle.
        // The bottom row is written with zeros.
        mem_re    = copy_phase;
        mem_raddr = cnt_q + ROW_STEP;
        wv_d      = 1'b1;
        wa_d      = cnt_q;
        wcopy_d   = copy_phase;
        cnt_d     = (cnt_q == CELL_LAST) ? '0 : cnt_q + AW'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.cursor_position = pos_ext[10:0];
          out_d.cell_char       = rchar_q;
          out_d.cell_attribute  = rattr_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      pos_q       <= '0;
      base_q      <= '0;
      wv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      col_q       <= col_d;
      row_q       <= row_d;
      pos_q       <= pos_d;
      base_q      <= base_d;
      wv_q        <= wv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rchar_q <= rchar_d;
    rattr_q <= rattr_d;
    wa_q    <= wa_d;
    wcopy_q <= wcopy_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
